FILE: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
// Both expect clk and rst to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define SCFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising edge, reset included.
`define SCFB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/scfb_pkg.sv
// ----------------------------------------------------------------------------
// scfb_pkg
// Frame constants, command codes and shared types of the command frame builder.
// ----------------------------------------------------------------------------
package scfb_pkg;

  localparam logic [7:0] SOF_BYTE = 8'h67;
  localparam logic [7:0] SEP_BYTE = 8'hF0;
  localparam logic [7:0] EOF_BYTE = 8'h99;

  localparam logic [7:0] CMD_INSTALL   = 8'h57;
  localparam logic [7:0] CMD_RESET     = 8'h58;
  localparam logic [7:0] CMD_POWER     = 8'h10;
  localparam logic [7:0] CMD_PORT_OFF  = 8'h59;
  localparam logic [7:0] CMD_POWER_ON  = 8'h5A;
  localparam logic [7:0] CMD_FILE_REQ  = 8'h11;
  localparam logic [7:0] CMD_FILE_XFER = 8'h12;
  localparam logic [7:0] CMD_FILE_CALL = 8'h13;
  localparam logic [7:0] CMD_AREA_SEL  = 8'h14;

  // Index of the last header byte before the payload.
  localparam logic [3:0] HDR_LAST_IDX = 4'd4;
  localparam logic [3:0] PAYLOAD_IDX  = 4'd5;

  // One request as held while its bytes go out.
  typedef struct packed {
    logic        is_data;   // transfer data byte instead of a command
    logic        tail;      // request ends with checksum and trailer
    logic [3:0]  last_idx;  // index of the last byte this request emits
    logic [2:0]  plen;      // payload bytes emitted by a command request
    logic [7:0]  len_byte;
    logic [7:0]  cmd;
    logic [7:0]  dest;
    logic [7:0]  port;
    logic [15:0] on_time;
    logic [7:0]  op;
    logic [7:0]  area;
    logic [7:0]  id;
    logic [31:0] size;
    logic [7:0]  flag;
    logic [7:0]  chunk;
    logic [7:0]  data;
  } item_t;

  // Byte chosen for the current index and how it is handled.
  typedef struct packed {
    logic [7:0] data;
    logic       summed;     // add into the checksum
    logic       clear_sum;  // start of frame, restart the checksum
    logic       last;       // last byte of the request
    logic       frame_end;  // trailer byte
  } sel_t;

endpackage

FILE: hw/rtl/scfb_byte_sel.sv
// ----------------------------------------------------------------------------
// scfb_byte_sel
// Picks the frame byte for the held request at the given byte index.
// ----------------------------------------------------------------------------
module scfb_byte_sel
  import scfb_pkg::*;
(
  input  item_t      item,
  input  logic [3:0] idx,
  input  logic [7:0] sum,
  output sel_t       sel
);

  logic [3:0] rel;
  logic [7:0] pbyte;

  assign rel = idx - PAYLOAD_IDX;

  // Payload byte by position, per command layout.
  always_comb begin
    pbyte = 8'h00;
    case (item.cmd)
      CMD_INSTALL, CMD_RESET, CMD_POWER, CMD_PORT_OFF: pbyte = item.port;
      CMD_POWER_ON: begin
        case (rel[1:0])
          2'd0:    pbyte = item.port;
          2'd1:    pbyte = item.on_time[15:8];
          default: pbyte = item.on_time[7:0];
        endcase
      end
      CMD_FILE_REQ: begin
        case (rel[2:0])
          3'd0:    pbyte = item.op;
          3'd1:    pbyte = item.area;
          3'd2:    pbyte = item.id;
          3'd3:    pbyte = item.size[31:24];
          3'd4:    pbyte = item.size[23:16];
          3'd5:    pbyte = item.size[15:8];
          default: pbyte = item.size[7:0];
        endcase
      end
      CMD_FILE_XFER: pbyte = rel[0] ? item.chunk : item.flag;
      CMD_FILE_CALL: begin
        case (rel[1:0])
          2'd0:    pbyte = item.port;
          2'd1:    pbyte = item.area;
          default: pbyte = item.id;
        endcase
      end
      CMD_AREA_SEL: pbyte = item.area;
      default:      pbyte = 8'h00;
    endcase
  end

  always_comb begin
    sel.data      = 8'h00;
    sel.summed    = 1'b0;
    sel.clear_sum = 1'b0;
    sel.frame_end = 1'b0;
    sel.last      = (idx == item.last_idx);
    if (item.is_data) begin
      case (idx)
        4'd0: begin
          sel.data   = item.data;
          sel.summed = 1'b1;
        end
        4'd1:    sel.data = sum;
        default: begin
          sel.data      = EOF_BYTE;
          sel.frame_end = 1'b1;
        end
      endcase
    end else begin
      case (idx)
        4'd0: begin
          sel.data      = SOF_BYTE;
          sel.clear_sum = 1'b1;
        end
        4'd1: begin
          sel.data   = item.len_byte;
          sel.summed = 1'b1;
        end
        4'd2: begin
          sel.data   = item.dest;
          sel.summed = 1'b1;
        end
        4'd3: begin
          sel.data   = SEP_BYTE;
          sel.summed = 1'b1;
        end
        HDR_LAST_IDX: begin
          sel.data   = item.cmd;
          sel.summed = 1'b1;
        end
        default: begin
          if (rel < {1'b0, item.plen}) begin
            sel.data   = pbyte;
            sel.summed = 1'b1;
          end else if (rel == {1'b0, item.plen}) begin
            sel.data = sum;
          end else begin
            sel.data      = EOF_BYTE;
            sel.frame_end = 1'b1;
          end
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/serial_command_frame_builder.sv
// ----------------------------------------------------------------------------
// serial_command_frame_builder
// Serializes command requests into checksummed byte frames.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side (s_*) takes one request per handshake: a command with its
//   fields, or, after a file transfer command, one data byte per request.
//   Master side (m_*) delivers the frame one byte per handshake; m_tlast
//   marks the trailer byte 0x99.
//   A command request emits 7 to 14 bytes, one per cycle unless the
//   receiver stalls, so the slave side takes the next request only as the
//   last of them moves out. The output shift through the byte index is the
//   limiting unit. A transfer data byte emits one byte (three for the
//   last one, with checksum and trailer), so data streams at one request
//   per cycle unless the receiver stalls. Reset clears the output register,
//   the pending data count and the checksum; the first request after reset
//   is taken as a command. When the receiver stalls, the output register
//   holds its byte and the byte walk pauses; a new request is taken in the
//   same cycle the last byte of the current one moves into the output
//   register.
// ----------------------------------------------------------------------------
module serial_command_frame_builder
  import scfb_pkg::*;
#(
  parameter int MAX_PAYLOAD = 246
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // destination[7:0], port_index[15:8], on_time[31:16], file_op_kind[39:32],
  // storage_area[47:40], file_id[55:48], byte_count[87:56],
  // final_chunk_flag[95:88], chunk_number[103:96], payload_count[111:104],
  // payload_byte[119:112]
  input  logic [119:0] s_tdata,
  // command_code[7:0]
  input  logic [7:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // frame_byte[7:0]
  output logic [7:0]   m_tdata,
  output logic         m_tlast
);

  localparam logic [7:0] MaxCnt = 8'(MAX_PAYLOAD);

  // Held request and byte walk.
  item_t      item;
  item_t      item_next;
  logic       busy;
  logic [3:0] idx;
  logic [7:0] sum;
  logic [7:0] pending;
  logic [7:0] pending_next;

  // Output register.
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_end;

  sel_t       sel;
  logic       out_free;
  logic       emit;
  logic       accept;
  logic [7:0] cnt;
  logic [7:0] cmd;

  assign out_free = !out_valid || m_tready;
  assign emit     = busy && out_free;
  assign s_tready = !busy || (out_free && sel.last);
  assign accept   = s_tvalid && s_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_end;

  assign cmd = s_tuser;
  assign cnt = (s_tdata[111:104] > MaxCnt) ? MaxCnt : s_tdata[111:104];

  // Decode the incoming request into the held form.
  always_comb begin
    item_next          = '0;
    item_next.cmd      = cmd;
    item_next.dest     = s_tdata[7:0];
    item_next.port     = s_tdata[15:8];
    item_next.on_time  = s_tdata[31:16];
    item_next.op       = s_tdata[39:32];
    item_next.area     = s_tdata[47:40];
    item_next.id       = s_tdata[55:48];
    item_next.size     = s_tdata[87:56];
    item_next.flag     = s_tdata[95:88];
    item_next.chunk    = s_tdata[103:96];
    item_next.data     = s_tdata[119:112];
    pending_next       = pending;
    if (pending != 8'd0) begin
      // Data byte of a running transfer; the last one closes the frame.
      item_next.is_data  = 1'b1;
      item_next.tail     = (pending == 8'd1);
      item_next.last_idx = item_next.tail ? 4'd2 : 4'd0;
      pending_next       = pending - 8'd1;
    end else begin
      item_next.tail = 1'b1;
      case (cmd)
        CMD_INSTALL, CMD_RESET, CMD_POWER, CMD_PORT_OFF: item_next.plen = 3'd1;
        CMD_POWER_ON:  item_next.plen = 3'd3;
        CMD_FILE_REQ:  item_next.plen = 3'd7;
        CMD_FILE_XFER: begin
          item_next.plen = 3'd2;
          item_next.tail = (cnt == 8'd0);
          pending_next   = cnt;
        end
        CMD_FILE_CALL: item_next.plen = 3'd3;
        CMD_AREA_SEL:  item_next.plen = 3'd1;
        default:       item_next.plen = 3'd0;
      endcase
      item_next.len_byte = 8'd7 + {5'd0, item_next.plen} +
                           ((cmd == CMD_FILE_XFER) ? cnt : 8'd0);
      item_next.last_idx = HDR_LAST_IDX + {1'b0, item_next.plen} +
                           (item_next.tail ? 4'd2 : 4'd0);
    end
  end

  scfb_byte_sel u_sel (
    .item (item),
    .idx  (idx),
    .sum  (sum),
    .sel  (sel)
  );

  // Payload of the held request: load on accept only.
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

  // Byte walk, checksum and pending data count.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      idx     <= 4'd0;
      sum     <= 8'd0;
      pending <= 8'd0;
    end else begin
      if (accept) begin
        busy    <= 1'b1;
        idx     <= 4'd0;
        pending <= pending_next;
      end else if (emit) begin
        idx <= idx + 4'd1;
        if (sel.last) begin
          busy <= 1'b0;
        end
      end
      if (emit) begin
        if (sel.clear_sum) begin
          sum <= 8'd0;
        end else if (sel.summed) begin
          sum <= sum + sel.data;
        end
      end
    end
  end

  // Output register: load on a free slot, drop the byte once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= sel.data;
      out_end  <= sel.frame_end;
    end
  end

endmodule

FILE: hw/rtl/scfb_checker.sv
// ----------------------------------------------------------------------------
// scfb_checker
// Port-level checks of the command frame builder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scfb_checker
  import scfb_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [119:0] s_tdata,
  input logic [7:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [7:0]   m_tdata,
  input logic         m_tlast
);

  logic s_seen;

  // Any slave-side activity, kept so every port is looked at.
  assign s_seen = s_tvalid && s_tready && ((|s_tdata) || (|s_tuser) || 1'b1);

  // A stalled byte holds until taken.
  `SCFB_ASSERT(a_hold_stall, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output byte changed while stalled")

  // The frame end marker only rides on the trailer byte.
  `SCFB_ASSERT(a_tlast_trailer, m_tvalid && m_tlast |-> m_tdata == EOF_BYTE, "tlast on a byte other than the trailer")

  // Reset empties the output register.
  `SCFB_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "output valid after reset")

  // An idle output wakes up only after an accepted request.
  `SCFB_ASSERT(a_cause, $rose(m_tvalid) |-> $past(s_seen, 2), "output byte without a request")

endmodule

bind serial_command_frame_builder scfb_checker u_scfb_checker (.*);
